// ===== hw/rtl/rrd_pkg.sv =====
// Package for the reflect/refract direction block: widths, register indexes,
// pipeline latency, the stage record and fixed-point helpers.
// No dependencies.
package rrd_pkg;

  localparam int FracBits  = 14;
  localparam int EtaBits   = 16;
  localparam int IdxW      = 14;
  localparam int EtaW      = 19;
  localparam int NumW      = IdxW + EtaBits;
  localparam int SqrtSteps = 18;
  localparam int SqW       = 37;
  localparam int Latency   = 9 + SqrtSteps;

  localparam logic [EtaW-1:0] EtaCap     = {EtaW{1'b1}};
  localparam logic [EtaW-1:0] EtaReset   = 19'd43984;
  localparam logic [IdxW-1:0] N1Reset    = 14'd4096;
  localparam logic [IdxW-1:0] N2Reset    = 14'd6103;

  typedef enum logic [1:0] {
    RegIncident    = 2'd0,
    RegTransmitted = 2'd1
  } reg_idx_e;

  // Record that travels with an item through the root stages and after
  typedef struct packed {
    logic        [2:0][15:0] n;
    logic        [2:0][15:0] r;
    logic        [2:0][19:0] ed;
    logic signed [19:0]      ec;
    logic signed [15:0]      c;
    logic                    tir;
    logic        [SqW-1:0]   v;
    logic        [SqW-1:0]   res;
  } carry_t;

  // Saturate to 16-bit signed
  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) begin
      return 16'sh7fff;
    end else if (v < -40'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

// ===== hw/rtl/reflect_refract_direction.sv =====
// Top level of the reflect/refract direction block: 27-stage pipeline plus
// the serial divider that derives the index ratio. Depends on rrd_pkg.

// One ray per cycle enters while busy is low; its result appears on the
// result ports with done_o high once it has passed every pipeline stage,
// and is shown for a single cycle only (the receiver cannot stall).
// Most of the latency is in the 18-stage bit-per-stage square root. Writing
// either refractive index starts a restoring divider for n1/n2 (a zero n2
// caps the ratio instead); busy stays high and cfg_ready_o stays low until the ratio is ready.
module reflect_refract_direction
  import rrd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [15:0]      dir_x_i,
  input  logic signed [15:0]      dir_y_i,
  input  logic signed [15:0]      dir_z_i,
  input  logic signed [15:0]      norm_x_i,
  input  logic signed [15:0]      norm_y_i,
  input  logic signed [15:0]      norm_z_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [IdxW-1:0]         cfg_data_i,
  output logic                    done_o,
  output logic signed [15:0]      refl_x_o,
  output logic signed [15:0]      refl_y_o,
  output logic signed [15:0]      refl_z_o,
  output logic signed [15:0]      refr_x_o,
  output logic signed [15:0]      refr_y_o,
  output logic signed [15:0]      refr_z_o,
  output logic signed [15:0]      cos_incidence_o,
  output logic                    total_reflection_o
);

  // ---------------- configuration and divider ----------------
  logic [IdxW-1:0] n1_q, n1_d, n2_q, n2_d;
  logic [EtaW-1:0] eta_q, eta_d;
  logic            div_busy_q, div_busy_d;
  logic [4:0]      div_cnt_q, div_cnt_d;
  logic [NumW-1:0] div_num_q, div_num_d;
  logic [IdxW-1:0] div_rem_q, div_rem_d, div_den_q, div_den_d;
  logic [IdxW:0]   div_trial, div_diff;
  logic            div_ge, cfg_wr;

  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o = !div_busy_q;
  assign busy        = div_busy_q;

  assign div_trial = {div_rem_q, div_num_q[NumW-1]};
  assign div_diff  = div_trial - {1'b0, div_den_q};
  assign div_ge    = div_trial >= {1'b0, div_den_q};

  // Launch on an index write (or cap the ratio when n2 is zero), then shift one quotient bit a cycle
  always_comb begin
    n1_d       = n1_q;
    n2_d       = n2_q;
    eta_d      = eta_q;
    div_busy_d = div_busy_q;
    div_cnt_d  = div_cnt_q;
    div_num_d  = div_num_q;
    div_rem_d  = div_rem_q;
    div_den_d  = div_den_q;
    if (div_busy_q) begin
      div_rem_d = div_ge ? div_diff[IdxW-1:0] : div_trial[IdxW-1:0];
      div_num_d = {div_num_q[NumW-2:0], div_ge};
      div_cnt_d = div_cnt_q + 5'd1;
      if (div_cnt_q == 5'(NumW - 1)) begin
        div_busy_d = 1'b0;
        eta_d = (div_num_d > NumW'(EtaCap)) ? EtaCap : div_num_d[EtaW-1:0];
      end
    end else if (cfg_wr && (cfg_index_i == RegIncident || cfg_index_i == RegTransmitted)) begin
      if (cfg_index_i == RegIncident) begin
        n1_d = cfg_data_i;
      end else begin
        n2_d = cfg_data_i;
      end
      if (n2_d == '0) begin
        eta_d = EtaCap;
      end else begin
        div_busy_d = 1'b1;
        div_cnt_d  = '0;
        div_num_d  = {n1_d, {EtaBits{1'b0}}} + NumW'(n2_d >> 1);
        div_rem_d  = '0;
        div_den_d  = n2_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_q       <= N1Reset;
      n2_q       <= N2Reset;
      eta_q      <= EtaReset;
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      n1_q       <= n1_d;
      n2_q       <= n2_d;
      eta_q      <= eta_d;
      div_busy_q <= div_busy_d;
      div_cnt_q  <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_num_q <= div_num_d;
    div_rem_q <= div_rem_d;
    div_den_q <= div_den_d;
  end

  // ---------------- valid bits ----------------
  logic [Latency-1:0] vld_q;
  logic               accept;

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-2:0], accept};
    end
  end

  // ---------------- stage 1: dot products ----------------
  logic signed [2:0][15:0] d1_q, n1v_q;
  logic signed [2:0][31:0] p1_q;

  always_ff @(posedge clk_i) begin
    d1_q    <= {dir_z_i, dir_y_i, dir_x_i};
    n1v_q   <= {norm_z_i, norm_y_i, norm_x_i};
    p1_q[0] <= norm_x_i * dir_x_i;
    p1_q[1] <= norm_y_i * dir_y_i;
    p1_q[2] <= norm_z_i * dir_z_i;
  end

  // ---------------- stage 2: cosine ----------------
  logic signed [35:0]      dot2, ndot2;
  logic signed [39:0]      c_wide2;
  logic signed [2:0][15:0] d2_q, n2v_q;
  logic signed [15:0]      c2_q;

  always_comb begin
    dot2    = 36'(signed'(p1_q[0])) + 36'(signed'(p1_q[1])) + 36'(signed'(p1_q[2]));
    ndot2   = -dot2 + 36'sd8192;
    c_wide2 = 40'(ndot2 >>> FracBits);
  end

  always_ff @(posedge clk_i) begin
    d2_q  <= d1_q;
    n2v_q <= n1v_q;
    c2_q  <= sat16(c_wide2);
  end

  // ---------------- stage 3: products with c and eta ----------------
  logic signed [19:0]      eta_s;
  logic signed [2:0][15:0] d3_q, n3v_q;
  logic signed [15:0]      c3_q;
  logic signed [31:0]      cc3_q;
  logic signed [2:0][31:0] cn3_q;
  logic signed [35:0]      ecp3_q;
  logic signed [2:0][35:0] edp3_q;
  logic [2*EtaW-1:0]       ee3_q;

  assign eta_s = signed'({1'b0, eta_q});

  always_ff @(posedge clk_i) begin
    d3_q   <= d2_q;
    n3v_q  <= n2v_q;
    c3_q   <= c2_q;
    cc3_q  <= c2_q * c2_q;
    for (int i = 0; i < 3; i++) begin
      cn3_q[i]  <= c2_q * signed'(n2v_q[i]);
      edp3_q[i] <= eta_s * signed'(d2_q[i]);
    end
    ecp3_q <= eta_s * c2_q;
    ee3_q  <= eta_q * eta_q;
  end

  // ---------------- stage 4: reflection and rounded terms ----------------
  logic signed [2:0][15:0] n4v_q, r4_q;
  logic signed [15:0]      c4_q;
  logic signed [18:0]      s4_q;
  logic [22:0]             e24_q;
  logic signed [19:0]      ec4_q;
  logic signed [2:0][19:0] ed4_q;
  logic signed [2:0][35:0] rsum4;
  logic signed [33:0]      ssum4;
  logic [2*EtaW:0]         esum4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum4[i] = (36'(signed'(d3_q[i])) <<< FracBits) + (36'(signed'(cn3_q[i])) <<< 1)
               + 36'sd8192;
    end
    ssum4 = 34'sd268435456 - 34'(cc3_q) + 34'sd8192;
    esum4 = {1'b0, ee3_q} + (2*EtaW+1)'(32768);
  end

  always_ff @(posedge clk_i) begin
    n4v_q <= n3v_q;
    c4_q  <= c3_q;
    for (int i = 0; i < 3; i++) begin
      r4_q[i]  <= sat16(40'(signed'(rsum4[i]) >>> FracBits));
      ed4_q[i] <= 20'((signed'(edp3_q[i]) + 36'sd32768) >>> EtaBits);
    end
    s4_q  <= 19'(ssum4 >>> FracBits);
    e24_q <= esum4[38:16];
    ec4_q <= 20'((ecp3_q + 36'sd32768) >>> EtaBits);
  end

  // ---------------- stage 5: eta^2 times s ----------------
  logic signed [2:0][15:0] n5v_q, r5_q;
  logic signed [15:0]      c5_q;
  logic signed [19:0]      ec5_q;
  logic signed [2:0][19:0] ed5_q;
  logic signed [42:0]      es5_q;

  always_ff @(posedge clk_i) begin
    n5v_q <= n4v_q;
    r5_q  <= r4_q;
    c5_q  <= c4_q;
    ec5_q <= ec4_q;
    ed5_q <= ed4_q;
    es5_q <= signed'({1'b0, e24_q}) * s4_q;
  end

  // ---------------- stage 6: radicand ----------------
  logic signed [42:0] rad6;
  logic               tir6;
  carry_t             c6;
  carry_t             sq_q [SqrtSteps+1];

  always_comb begin
    rad6     = 43'sd16384 - ((es5_q + 43'sd32768) >>> EtaBits);
    tir6     = rad6 < 0;
    c6.n     = n5v_q;
    c6.r     = r5_q;
    c6.ed    = ed5_q;
    c6.ec    = ec5_q;
    c6.c     = c5_q;
    c6.tir   = tir6;
    c6.v     = tir6 ? '0 : (SqW'(rad6[21:0]) << FracBits);
    c6.res   = '0;
  end

  always_ff @(posedge clk_i) begin
    sq_q[0] <= c6;
  end

  // ---------------- square root: one result bit per stage ----------------
  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    localparam logic [SqW-1:0] Bit = SqW'(1) << (2 * (SqrtSteps - 1 - j));
    logic [SqW-1:0] trial;
    carry_t         nxt;

    always_comb begin
      trial = sq_q[j].res + Bit;
      nxt   = sq_q[j];
      if (sq_q[j].v >= trial) begin
        nxt.v   = sq_q[j].v - trial;
        nxt.res = (sq_q[j].res >> 1) + Bit;
      end else begin
        nxt.res = sq_q[j].res >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      sq_q[j+1] <= nxt;
    end
  end

  // ---------------- stage m: bend factor ----------------
  carry_t             cm_q;
  logic signed [20:0] m_q;

  always_ff @(posedge clk_i) begin
    cm_q <= sq_q[SqrtSteps];
    m_q  <= 21'(sq_q[SqrtSteps].ec) - signed'({2'b0, sq_q[SqrtSteps].res[18:0]});
  end

  // ---------------- stage mn: bend factor times normal ----------------
  carry_t                  cn_q;
  logic signed [2:0][36:0] mn_q;

  always_ff @(posedge clk_i) begin
    cn_q <= cm_q;
    for (int i = 0; i < 3; i++) begin
      mn_q[i] <= m_q * signed'(cm_q.n[i]);
    end
  end

  // ---------------- output register ----------------
  logic signed [2:0][39:0] tsum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tsum[i] = 40'(signed'(cn_q.ed[i]))
              + 40'((signed'(mn_q[i]) + 37'sd8192) >>> FracBits);
    end
  end

  always_ff @(posedge clk_i) begin
    refl_x_o           <= cn_q.r[0];
    refl_y_o           <= cn_q.r[1];
    refl_z_o           <= cn_q.r[2];
    refr_x_o           <= cn_q.tir ? '0 : sat16(tsum[0]);
    refr_y_o           <= cn_q.tir ? '0 : sat16(tsum[1]);
    refr_z_o           <= cn_q.tir ? '0 : sat16(tsum[2]);
    cos_incidence_o    <= cn_q.c;
    total_reflection_o <= cn_q.tir;
  end

  assign done_o = vld_q[Latency-1];

endmodule

// ===== hw/rtl/rrd_checker.sv =====
// Port-level checker for the reflect/refract direction block, with its bind.
// Depends on rrd_pkg.
module rrd_checker
  import rrd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic               done_o,
  input logic signed [15:0] refr_x_o,
  input logic signed [15:0] refr_y_o,
  input logic signed [15:0] refr_z_o,
  input logic               total_reflection_o
);

  // Every taken ray comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##Latency done_o) else $error("result missing");

  // No result without a ray taken the latency earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency)) else $error("spurious result");

  // Total reflection leaves no refracted ray
  a_tir_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && total_reflection_o |-> refr_x_o == 0 && refr_y_o == 0 && refr_z_o == 0)
    else $error("refracted ray on total reflection");

  // Config port and ray port are closed together while the ratio settles
  a_busy_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy == !cfg_ready_o) else $error("busy and cfg ready disagree");

endmodule

bind reflect_refract_direction rrd_checker u_rrd_checker (.*);

// ===== dv/reflect_refract_direction_tb.sv =====
// Self-checking testbench for the reflect/refract direction block.
// Holds its own fixed-point ray predictor; depends on rrd_pkg and the block.
module reflect_refract_direction_tb;
  import rrd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] d [3];
    logic signed [15:0] n [3];
  } ray_t;

  typedef struct {
    logic signed [15:0] refl [3];
    logic signed [15:0] refr [3];
    logic signed [15:0] cosi;
    logic               tir;
  } bounce_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic signed [15:0] norm_x_i = '0, norm_y_i = '0, norm_z_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [IdxW-1:0] cfg_data_i = '0;
  logic done_o;
  logic signed [15:0] refl_x_o, refl_y_o, refl_z_o;
  logic signed [15:0] refr_x_o, refr_y_o, refr_z_o;
  logic signed [15:0] cos_incidence_o;
  logic total_reflection_o;

  reflect_refract_direction uut (.*);

  always #4 clk_i = ~clk_i;

  ray_t    ray_queue [$];
  bounce_t bounce_queue [$];
  int      errors = 0;
  int      send_idle_pct = 0;
  logic [IdxW-1:0] n1 = N1Reset;
  logic [IdxW-1:0] n2 = N2Reset;

  // Round half up of v / 2^s
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'd3037000499;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Predict reflection, refraction and incidence cosine of one ray
  function automatic bounce_t trace_ray(ray_t ry);
    bounce_t b;
    longint dv [3], nv [3];
    longint dot, c, eta, s, e2, rad, k, m;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      dv[i] = ry.d[i];
      nv[i] = ry.n[i];
      dot += dv[i] * nv[i];
    end
    c = clamp16(round_shift(-dot, FracBits));
    for (int i = 0; i < 3; i++)
      b.refl[i] = 16'(clamp16(round_shift(dv[i] * (1 << FracBits) + 2 * c * nv[i], FracBits)));
    if (n2 == 0) eta = EtaCap;
    else begin
      eta = ((longint'(n1) << EtaBits) + (n2 >> 1)) / n2;
      if (eta > EtaCap) eta = EtaCap;
    end
    s = round_shift((longint'(1) << (2 * FracBits)) - c * c, FracBits);
    e2 = round_shift(eta * eta, EtaBits);
    rad = (longint'(1) << FracBits) - round_shift(e2 * s, EtaBits);
    b.tir = rad < 0;
    for (int i = 0; i < 3; i++) b.refr[i] = '0;
    if (!b.tir) begin
      k = int_sqrt(rad << FracBits);
      m = round_shift(eta * c, EtaBits) - k;
      for (int i = 0; i < 3; i++)
        b.refr[i] = 16'(clamp16(round_shift(eta * dv[i], EtaBits)
                               + round_shift(m * nv[i], FracBits)));
    end
    b.cosi = 16'(c);
    return b;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // Driver: present the next ray word, predict it when taken
  always @(posedge clk_i) begin
    if (start && !busy) begin
      ray_t taken;
      taken.d = '{dir_x_i, dir_y_i, dir_z_i};
      taken.n = '{norm_x_i, norm_y_i, norm_z_i};
      bounce_queue.push_back(trace_ray(taken));
    end
    if (start && busy) begin
      // hold the word until taken
    end else if (ray_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      ray_t nx;
      nx = ray_queue.pop_front();
      start <= 1'b1;
      dir_x_i <= nx.d[0]; dir_y_i <= nx.d[1]; dir_z_i <= nx.d[2];
      norm_x_i <= nx.n[0]; norm_y_i <= nx.n[1]; norm_z_i <= nx.n[2];
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: check each result word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (bounce_queue.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        bounce_t w;
        w = bounce_queue.pop_front();
        if (refl_x_o !== w.refl[0]) report_mismatch("refl_x", refl_x_o, w.refl[0]);
        if (refl_y_o !== w.refl[1]) report_mismatch("refl_y", refl_y_o, w.refl[1]);
        if (refl_z_o !== w.refl[2]) report_mismatch("refl_z", refl_z_o, w.refl[2]);
        if (refr_x_o !== w.refr[0]) report_mismatch("refr_x", refr_x_o, w.refr[0]);
        if (refr_y_o !== w.refr[1]) report_mismatch("refr_y", refr_y_o, w.refr[1]);
        if (refr_z_o !== w.refr[2]) report_mismatch("refr_z", refr_z_o, w.refr[2]);
        if (cos_incidence_o !== w.cosi)
          report_mismatch("cos_incidence", cos_incidence_o, w.cosi);
        if (total_reflection_o !== w.tir)
          report_mismatch("total_reflection", total_reflection_o, w.tir);
      end
    end
  end

  // Wait until every queued ray has been taken and answered
  task automatic drain();
    while (ray_queue.size() > 0 || start) @(posedge clk_i);
    while (bounce_queue.size() > 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // Write one index register while the block is idle
  task automatic write_index(reg_idx_e idx, logic [IdxW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == RegIncident) n1 = val;
    else n2 = val;
    @(posedge clk_i);
    while (busy || !cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic add_ray(int dx, int dy, int dz, int nx, int ny, int nz);
    ray_t r;
    r.d = '{16'(dx), 16'(dy), 16'(dz)};
    r.n = '{16'(nx), 16'(ny), 16'(nz)};
    ray_queue.push_back(r);
  endtask

  // Mostly unit-ish vectors, some full-range noise
  task automatic add_random_ray();
    ray_t r;
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(9) < 7) begin
        r.d[i] = 16'($urandom_range(32767) - 16384);
        r.n[i] = 16'($urandom_range(32767) - 16384);
      end else begin
        r.d[i] = 16'($urandom);
        r.n[i] = 16'($urandom);
      end
    end
    if ($urandom_range(3) == 0) r.n = '{16'sd0, 16'sd0, 16'sd16384};
    ray_queue.push_back(r);
  endtask

  initial begin
    logic [IdxW-1:0] settings [6][2];
    settings = '{'{4096, 6103}, '{16383, 4096}, '{4096, 16383},
                 '{6103, 4096}, '{4096, 4096}, '{16383, 16383}};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // Directed rays: head-on, grazing, extremes, non-unit
    add_ray(0, 0, -16384, 0, 0, 16384);
    add_ray(16384, 0, 0, 0, 0, 16384);
    add_ray(11585, 0, -11585, 0, 0, 16384);
    add_ray(32767, 32767, 32767, 32767, 32767, 32767);
    add_ray(-32768, -32768, -32768, -32768, -32768, -32768);
    add_ray(-32768, 32767, 0, 32767, -32768, 0);
    add_ray(0, 0, 0, 0, 0, 0);
    add_ray(-1, -1, -1, -1, -1, -1);
    add_ray(15000, 0, -6600, 0, 0, 16384);
    drain();
    // High ratio: total internal reflection
    write_index(RegIncident, 16383);
    write_index(RegTransmitted, 4096);
    add_ray(15000, 0, -6600, 0, 0, 16384);
    add_ray(0, 0, -16384, 0, 0, 16384);
    add_ray(11585, 0, -11585, 0, 0, 16384);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_index(RegIncident, settings[ph][0]);
      write_index(RegTransmitted, settings[ph][1]);
      send_idle_pct = (ph < 2) ? 18 : (ph < 4) ? 83 : 0;
      for (int j = 0; j < 92; j++) add_random_ray();
      drain();
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rrd_pkg.sv
hw/rtl/reflect_refract_direction.sv
hw/rtl/rrd_checker.sv
dv/reflect_refract_direction_tb.sv
